[src/ettc_pkg.sv]
package ettc_pkg;
	localparam int SLOT_COUNT_DEF = 8;
	localparam int ROOM_MAX = 32;
	localparam int LIMIT_MAX = 8;

	localparam logic [2:0] CMD_START   = 3'd0;
	localparam logic [2:0] CMD_STOP    = 3'd1;
	localparam logic [2:0] CMD_RESTART = 3'd2;
	localparam logic [2:0] CMD_TICK    = 3'd3;
	localparam logic [2:0] CMD_QUERY   = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_ARG  = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_BAD_CFG  = 3'd4;

	localparam logic [1:0] REG_CATCHUP_EN  = 2'd0;
	localparam logic [1:0] REG_CATCHUP_LIM = 2'd1;
	localparam logic [1:0] REG_ZERO_DELAY  = 2'd2;

	// shared divider handshake
	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] quot;
		logic [31:0] rem;
	} div_rsp_t;
endpackage

[src/ettc_div.sv]
// Restoring divider, one quotient bit per cycle.
module ettc_div
	import ettc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [31:0] quot_q, rem_q, dsr_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [32:0] trial;

	assign trial = {rem_q, quot_q[31]} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
				quot_q <= req.dividend;
				rem_q  <= '0;
				dsr_q  <= req.divisor;
			end else if (busy_q) begin
				if (!trial[32]) begin
					rem_q <= trial[31:0];
					quot_q <= {quot_q[30:0], 1'b1};
				end else begin
					rem_q <= {rem_q[30:0], quot_q[31]};
					quot_q <= {quot_q[30:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;
endmodule

[src/event_timer_table_with_catchup.sv]
// Timer table with periodic catch-up. Each input transfer is one command
// (start, stop, restart, tick, query); its results leave on the master side,
// events of a tick first, then one status transfer with tlast high. The
// block takes one command at a time. Start, stop, restart and query walk
// the slots one per cycle. A tick with nonzero elapsed time visits every
// slot in index order; an overdue periodic slot runs the shared serial
// divider. No clearing pass: reset clears the slot flip-flops directly.
module event_timer_table_with_catchup
	import ettc_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// tdata: cmd[2:0], tmr[10:3], evt[18:11], event_source[26:19],
	// event_param[58:27], payload_word[90:59], delay[122:91],
	// is_periodic[123], elapsed[155:124], queue_room[161:156]
	input  logic [167:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// tdata: status[2:0], timer_active[3], ticks_left[35:4],
	// evt_out[43:36], out_source[51:44], out_param[83:52],
	// out_payload[115:84]
	output logic [119:0] m_tdata,
	output logic         m_tuser,   // result_kind
	output logic         m_tlast,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [3:0]   cfg_wdata
);
	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW = $clog2(SLOT_COUNT + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_FIND, S_EXEC, S_TICK, S_DIV, S_POST, S_RELOAD, S_STATUS
	} state_t;
	state_t state_q;

	logic       cen_q, zda_q;
	logic [3:0] clim_q;

	logic [7:0]  id_q [SLOT_COUNT];
	logic [31:0] rem_q [SLOT_COUNT];
	logic [31:0] per_q [SLOT_COUNT];
	logic [7:0]  ev_q [SLOT_COUNT];
	logic [7:0]  src_q [SLOT_COUNT];
	logic [31:0] par_q [SLOT_COUNT];
	logic [31:0] pay_q [SLOT_COUNT];
	logic        prd_q [SLOT_COUNT];
	logic        act_q [SLOT_COUNT];

	logic [2:0]  cmd_q;
	logic [7:0]  tid_q, eid_q, esrc_q;
	logic [31:0] epar_q, epay_q, dly_q, el_q;
	logic        iper_q;
	logic [5:0]  room_q;

	logic [CW-1:0] idx_q;
	logic [IW-1:0] hit_q, free_q;
	logic          hit_v_q, free_v_q;
	logic [3:0]    cnt_q;
	logic [2:0]    st_q;
	logic          qact_q;
	logic [31:0]   qleft_q;

	logic          o_valid_q, o_kind_q, o_last_q;
	logic [119:0]  o_data_q;

	div_req_t dreq;
	div_rsp_t drsp;

	ettc_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic [IW-1:0] cur;
	assign cur = idx_q[IW-1:0];

	logic [31:0] over;
	assign over = el_q - rem_q[cur];
	assign dreq.dividend = over;
	assign dreq.divisor  = per_q[cur];
	assign dreq.start    = (state_q == S_TICK) && act_q[cur] && ev_q[cur] != 8'd0
		&& !(rem_q[cur] > el_q) && prd_q[cur] && per_q[cur] != 32'd0;

	// capped event count from quotient
	logic [3:0] lim_eff, cnt_calc;
	always_comb begin
		lim_eff = (clim_q == 4'd0) ? 4'd1 : (clim_q > 4'd8) ? 4'd8 : clim_q;
		if (!cen_q)
			cnt_calc = 4'd1;
		else if (drsp.quot >= {28'd0, lim_eff})
			cnt_calc = lim_eff;
		else
			cnt_calc = drsp.quot[3:0] + 4'd1;
		if (cnt_calc > lim_eff && cen_q)
			cnt_calc = lim_eff;
	end

	logic out_free;
	assign out_free = !o_valid_q || m_tready;

	// output register takes a new result this cycle
	logic o_load;
	assign o_load = out_free && ((state_q == S_STATUS)
		|| (state_q == S_POST && cnt_q != 4'd0 && room_q != 6'd0));

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = o_valid_q;
	assign m_tdata  = o_data_q;
	assign m_tuser  = o_kind_q;
	assign m_tlast  = o_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cen_q     <= 1'b1;
			clim_q    <= 4'd4;
			zda_q     <= 1'b0;
			o_valid_q <= 1'b0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				id_q[i] <= '0; rem_q[i] <= '0; per_q[i] <= '0; ev_q[i] <= '0;
				src_q[i] <= '0; par_q[i] <= '0; pay_q[i] <= '0;
				prd_q[i] <= 1'b0; act_q[i] <= 1'b0;
			end
		end else begin
			if (o_load)
				o_valid_q <= 1'b1;
			else if (m_tready)
				o_valid_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_CATCHUP_EN:  cen_q  <= cfg_wdata[0];
					REG_CATCHUP_LIM: clim_q <= cfg_wdata;
					REG_ZERO_DELAY:  zda_q  <= cfg_wdata[0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: if (s_tvalid) begin
					cmd_q  <= s_tdata[2:0];
					tid_q  <= s_tdata[10:3];
					eid_q  <= s_tdata[18:11];
					esrc_q <= s_tdata[26:19];
					epar_q <= s_tdata[58:27];
					epay_q <= s_tdata[90:59];
					dly_q  <= s_tdata[122:91];
					iper_q <= s_tdata[123];
					el_q   <= s_tdata[155:124];
					room_q <= (s_tdata[161:156] > 6'd32) ? 6'd32 : s_tdata[161:156];
					idx_q  <= '0;
					hit_v_q  <= 1'b0;
					free_v_q <= 1'b0;
					hit_q  <= '0;
					free_q <= '0;
					st_q   <= ST_OK;
					qact_q <= 1'b0;
					qleft_q <= '0;
					if (s_tdata[2:0] == CMD_TICK)
						state_q <= (s_tdata[155:124] == 32'd0) ? S_STATUS : S_TICK;
					else if (s_tdata[2:0] > CMD_QUERY)
						state_q <= S_EXEC;
					else
						state_q <= S_FIND;
				end
				S_FIND: begin
					// one slot per cycle: first id match, first free slot
					if (!hit_v_q && id_q[cur] == tid_q) begin
						hit_v_q <= 1'b1; hit_q <= cur;
					end
					if (!free_v_q && id_q[cur] == 8'd0) begin
						free_v_q <= 1'b1; free_q <= cur;
					end
					if (idx_q == CW'(SLOT_COUNT - 1))
						state_q <= S_EXEC;
					idx_q <= idx_q + 1'b1;
				end
				S_EXEC: begin
					state_q <= S_STATUS;
					case (cmd_q)
						CMD_START: begin
							if (tid_q == 0 || eid_q == 0)
								st_q <= ST_BAD_ARG;
							else if (dly_q == 0 && (!zda_q || iper_q))
								st_q <= ST_BAD_ARG;
							else if (!hit_v_q && !free_v_q)
								st_q <= ST_FULL;
							else begin
								id_q[hit_v_q ? hit_q : free_q]  <= tid_q;
								rem_q[hit_v_q ? hit_q : free_q] <= dly_q;
								per_q[hit_v_q ? hit_q : free_q] <= dly_q;
								ev_q[hit_v_q ? hit_q : free_q]  <= eid_q;
								src_q[hit_v_q ? hit_q : free_q] <= esrc_q;
								par_q[hit_v_q ? hit_q : free_q] <= epar_q;
								pay_q[hit_v_q ? hit_q : free_q] <= epay_q;
								prd_q[hit_v_q ? hit_q : free_q] <= iper_q;
								act_q[hit_v_q ? hit_q : free_q] <= 1'b1;
							end
						end
						CMD_STOP, CMD_RESTART: begin
							if (tid_q == 0)
								st_q <= ST_BAD_ARG;
							else if (!hit_v_q)
								st_q <= ST_NOTFOUND;
							else if (cmd_q == CMD_STOP)
								act_q[hit_q] <= 1'b0;
							else if (per_q[hit_q] == 0 || ev_q[hit_q] == 0)
								st_q <= ST_BAD_CFG;
							else begin
								rem_q[hit_q] <= per_q[hit_q];
								act_q[hit_q] <= 1'b1;
							end
						end
						CMD_QUERY: begin
							if (tid_q != 0 && hit_v_q && ev_q[hit_q] != 0 && act_q[hit_q]) begin
								qact_q  <= 1'b1;
								qleft_q <= rem_q[hit_q];
							end
						end
						default: st_q <= ST_BAD_ARG;
					endcase
				end
				S_TICK: begin
					if (dreq.start)
						state_q <= S_DIV;
					else begin
						if (act_q[cur]) begin
							if (ev_q[cur] == 0) begin
								act_q[cur] <= 1'b0; rem_q[cur] <= '0;
							end else if (rem_q[cur] > el_q)
								rem_q[cur] <= rem_q[cur] - el_q;
							else if (!prd_q[cur]) begin
								act_q[cur] <= 1'b0; rem_q[cur] <= '0;
							end else begin
								act_q[cur] <= 1'b0; rem_q[cur] <= '0;
							end
						end
						if (act_q[cur] && ev_q[cur] != 0 && !(rem_q[cur] > el_q)
							&& !prd_q[cur]) begin
							cnt_q <= 4'd1;
							state_q <= S_POST;
						end else if (idx_q == CW'(SLOT_COUNT - 1))
							state_q <= S_STATUS;
						else
							idx_q <= idx_q + 1'b1;
					end
				end
				S_DIV: if (drsp.done) begin
					cnt_q <= cnt_calc;
					rem_q[cur] <= (drsp.rem == 0) ? per_q[cur] : per_q[cur] - drsp.rem;
					state_q <= S_POST;
				end
				S_POST: begin
					if (cnt_q == 0 || room_q == 0)
						state_q <= S_RELOAD;
					else if (out_free) begin
						o_kind_q  <= 1'b1;
						o_last_q  <= 1'b0;
						o_data_q  <= {4'd0, pay_q[cur], par_q[cur], src_q[cur], ev_q[cur],
							32'd0, 1'b0, ST_OK};
						room_q <= room_q - 6'd1;
						cnt_q  <= cnt_q - 4'd1;
					end
				end
				S_RELOAD: begin
					if (idx_q == CW'(SLOT_COUNT - 1))
						state_q <= S_STATUS;
					else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_TICK;
					end
				end
				S_STATUS: if (out_free) begin
					o_kind_q  <= 1'b0;
					o_last_q  <= 1'b1;
					o_data_q  <= {84'd0, qleft_q, qact_q, st_q};
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[src/ettc_check.sv]
module ettc_check (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [119:0] m_tdata,
	input logic         m_tuser,
	input logic         m_tlast
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed while stalled");
	a_evt_notlast: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !m_tlast)
		else $error("event marked last");
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("status not last");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready right after accept");
endmodule

bind event_timer_table_with_catchup ettc_check u_check (.*);
